// ===== rtl/core/swst_pkg.sv =====
// swst_pkg: shared constants, operation and register codes, and the
// command/status structs between the slot tracker controller and datapath.
// No dependencies.
package swst_pkg;

  // default window size limit
  localparam int MAX_SLOTS_DEF = 64;

  // field widths fixed by the stream format
  localparam int SEQ_W    = 16;
  localparam int LEN_W    = 16;
  localparam int MODE_W   = 3;
  localparam int SCOUNT_W = 7;
  localparam int SLOTO_W  = 6;
  localparam int CNTO_W   = 7;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE  = 1'd1;

  localparam logic [SCOUNT_W-1:0] SLOT_COUNT_RST = 7'd64;
  localparam logic [LEN_W-1:0]    SLOT_SIZE_RST  = 16'd1024;

  // operation codes carried in tuser
  localparam logic [MODE_W-1:0] MODE_SET_BASE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADVANCE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MARK     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNMARK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd4;

  typedef struct packed {
    logic load_in;   // latch the accepted input beat
    logic exec;      // apply the operation, read the addressed slot length
    logic sweep;     // free one slot of the advance range
    logic look;      // read the slot length after a sweep
    logic load_out;  // capture the result into the output register
  } swst_cmd_t;

  typedef struct packed {
    logic need_sweep;  // advance that frees slots one at a time
    logic sweep_last;  // current sweep step is the final one
  } swst_sts_t;

endpackage

// ===== rtl/core/swst_ram.sv =====
// swst_ram: generic simple dual port RAM, one write and one registered read.
// No dependencies.
module swst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/swst_ctrl.sv =====
// swst_ctrl: sequencer of the slot tracker, handshakes and step control.
// Depends on swst_pkg.
module swst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  swst_pkg::swst_sts_t sts,
  output swst_pkg::swst_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_LOOK,
    ST_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) || ((state == ST_RESP) && out_free);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.load_in  = accept;
    cmd.exec     = (state == ST_EXEC);
    cmd.sweep    = (state == ST_SWEEP);
    cmd.look     = (state == ST_LOOK);
    cmd.load_out = (state == ST_RESP) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = sts.need_sweep ? ST_SWEEP : ST_RESP;
      end
      ST_SWEEP: begin
        if (sts.sweep_last) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        // back into execute when the next beat is taken with the result
        if (out_free) state_next = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/swst_datapath.sv =====
// swst_datapath: window state, slot valid bits, slot length RAM, config
// registers and result register. Depends on swst_pkg and swst_ram.
module swst_datapath #(
  parameter int MAX_SLOTS = swst_pkg::MAX_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swst_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [swst_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [swst_pkg::MODE_W-1:0]         in_mode,
  input  swst_pkg::swst_cmd_t                 cmd,
  output swst_pkg::swst_sts_t                 sts,
  output logic [swst_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NW    = $clog2(MAX_SLOTS + 1);
  localparam int SW    = NW + 1;
  localparam int CW    = (NW > swst_pkg::SCOUNT_W) ? NW : swst_pkg::SCOUNT_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SLOTS);

  // configuration
  logic [swst_pkg::SCOUNT_W-1:0] slot_count;
  logic [swst_pkg::LEN_W-1:0]    slot_size;

  // latched input beat
  logic [swst_pkg::MODE_W-1:0] mode_q;
  logic [swst_pkg::SEQ_W-1:0]  seq_q;
  logic [swst_pkg::SEQ_W-1:0]  by_q;
  logic [swst_pkg::LEN_W-1:0]  len_q;

  // window state
  logic [swst_pkg::SEQ_W-1:0] base_seq;
  logic [IDX_W-1:0]           ring_start;
  logic [MAX_SLOTS-1:0]       slot_valid;
  logic [NW-1:0]              used_slots;
  logic [IDX_W-1:0]           sweep_ptr;
  logic [NW-1:0]              sweep_rem;

  logic [CW-1:0]              sc_ext;
  logic [NW-1:0]              n_eff;
  logic [swst_pkg::SEQ_W-1:0] off;
  logic                       hit;
  logic [SW-1:0]              slot_sum;
  logic [SW-1:0]              slot_wrap;
  logic [IDX_W-1:0]           slot;
  logic                       slot_busy;
  logic [swst_pkg::LEN_W-1:0] sat_len;
  logic                       adv_full;
  logic [SW-1:0]              ptr_inc;
  logic [IDX_W-1:0]           ptr_next;
  logic [swst_pkg::LEN_W-1:0] ram_rdata;
  logic                       ram_we;
  logic                       ram_re;

  logic                       res_in_use;
  logic [swst_pkg::LEN_W-1:0] res_len;
  logic [15:0]                slot_w;
  logic [15:0]                cnt_w;

  // effective window size: zero acts as one, clamp to the slot limit
  always_comb begin
    sc_ext = CW'(slot_count);
    if (sc_ext == '0) begin
      n_eff = NW'(1);
    end else if (sc_ext > MAX_C) begin
      n_eff = NW'(MAX_SLOTS);
    end else begin
      n_eff = NW'(sc_ext);
    end
  end

  // ring slot of seq; on a hit, offset and ring start are both below n_eff
  always_comb begin
    off       = seq_q - base_seq;
    hit       = off < swst_pkg::SEQ_W'(n_eff);
    slot_sum  = SW'(ring_start) + SW'(off[NW-1:0]);
    slot_wrap = (slot_sum >= SW'(n_eff)) ? (slot_sum - SW'(n_eff)) : slot_sum;
    slot      = hit ? IDX_W'(slot_wrap) : '0;
    slot_busy = hit && slot_valid[slot];
  end

  assign sat_len  = (len_q > slot_size) ? slot_size : len_q;
  assign adv_full = by_q >= swst_pkg::SEQ_W'(n_eff);
  assign ptr_inc  = SW'(sweep_ptr) + SW'(1);
  assign ptr_next = (ptr_inc == SW'(n_eff)) ? '0 : IDX_W'(ptr_inc);

  always_comb begin
    sts.need_sweep = (mode_q == swst_pkg::MODE_ADVANCE) && !adv_full && (by_q != '0);
    sts.sweep_last = (sweep_rem == NW'(1));
  end

  assign ram_we = cmd.exec && (mode_q == swst_pkg::MODE_MARK) && hit;
  assign ram_re = cmd.exec || cmd.look;

  swst_ram #(
    .WIDTH (swst_pkg::LEN_W),
    .DEPTH (MAX_SLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (sat_len),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_q <= in_mode;
      seq_q  <= in_data[15:0];
      by_q   <= in_data[31:16];
      len_q  <= in_data[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= swst_pkg::SLOT_COUNT_RST;
      slot_size  <= swst_pkg::SLOT_SIZE_RST;
      base_seq   <= '0;
      ring_start <= '0;
      slot_valid <= '0;
      used_slots <= '0;
      sweep_ptr  <= '0;
      sweep_rem  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swst_pkg::CFG_SLOT_COUNT: begin
          slot_count <= cfg_data[swst_pkg::SCOUNT_W-1:0];
          ring_start <= '0;
          slot_valid <= '0;
          used_slots <= '0;
        end
        swst_pkg::CFG_SLOT_SIZE: begin
          slot_size <= cfg_data[swst_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (cmd.exec) begin
      unique case (mode_q)
        swst_pkg::MODE_SET_BASE: begin
          base_seq   <= seq_q;
          ring_start <= '0;
          slot_valid <= '0;
          used_slots <= '0;
        end
        swst_pkg::MODE_ADVANCE: begin
          if (adv_full) begin
            base_seq   <= base_seq + by_q;
            ring_start <= '0;
            slot_valid <= '0;
            used_slots <= '0;
          end else if (by_q != '0) begin
            sweep_ptr <= ring_start;
            sweep_rem <= NW'(by_q);
          end
        end
        swst_pkg::MODE_MARK: begin
          if (hit && !slot_valid[slot]) begin
            slot_valid[slot] <= 1'b1;
            used_slots       <= used_slots + NW'(1);
          end
        end
        swst_pkg::MODE_UNMARK: begin
          if (slot_busy) begin
            slot_valid[slot] <= 1'b0;
            if (used_slots != '0) used_slots <= used_slots - NW'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.sweep) begin
      if (slot_valid[sweep_ptr]) begin
        slot_valid[sweep_ptr] <= 1'b0;
        if (used_slots != '0) used_slots <= used_slots - NW'(1);
      end
      sweep_ptr <= ptr_next;
      sweep_rem <= sweep_rem - NW'(1);
      // the pointer ends one past the freed range, which is the new ring start
      if (sts.sweep_last) begin
        base_seq   <= base_seq + by_q;
        ring_start <= ptr_next;
      end
    end
  end

  // a free slot reads as length zero; a mark forwards the value just written
  always_comb begin
    res_in_use = slot_busy;
    if (!slot_busy) begin
      res_len = '0;
    end else if (mode_q == swst_pkg::MODE_MARK) begin
      res_len = sat_len;
    end else begin
      res_len = ram_rdata;
    end
    slot_w = 16'(slot);
    cnt_w  = 16'(used_slots);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {1'b0, cnt_w[swst_pkg::CNTO_W-1:0], base_seq,
                   slot_w[swst_pkg::SLOTO_W-1:0], res_len, res_in_use, hit};
    end
  end

endmodule

// ===== rtl/core/sliding_window_slot_tracker.sv =====
// sliding_window_slot_tracker: top level of the transport window slot tracker.
// Depends on swst_pkg, swst_ctrl and swst_datapath.
//
// One input beat on s_* carries an operation (tuser) and its operands; each
// beat yields exactly one result beat on m_* describing seq after the step.
// Operations: set base, advance base, mark a sequence in use, unmark, query.
// The cfg channel writes slot_count (index 0, also frees every slot and
// rewinds the ring) and slot_size (index 1); cfg_ready is always high. The
// user must make writes only while no beat is in flight; the block does not
// enforce it. The input beat is latched, executed in the execute state, and
// its result registered in the response state; set base, mark, unmark, query
// and an advance by 0 or by at least the window size skip the sweep; an advance
// by k from 1 to window size - 1 sweeps k slots, one per cycle, then looks.
// The slot length RAM has one write and one registered read port; in-use
// flags sit in flops, so reset frees all slots at once with no clearing pass.
// Reset (rst, synchronous) restores slot_count 64, slot_size 1024, base 0.
// When m_tready is low the result holds in the output register; one more
// beat is taken and executed, then s_tready stays low until the result moves.
module sliding_window_slot_tracker #(
  parameter int MAX_SLOTS = swst_pkg::MAX_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // seq[15:0], advance_by[31:16], length[47:32]
  input  logic [swst_pkg::IN_DATA_W-1:0]      s_tdata,
  // mode[2:0]
  input  logic [swst_pkg::MODE_W-1:0]         s_tuser,
  // master stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // in_range[0], in_use[1], used_length[17:2], slot_index[23:18],
  // window_base[39:24], in_use_count[46:40], zero[47]
  output logic [swst_pkg::OUT_DATA_W-1:0]     m_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swst_pkg::CFG_DATA_W-1:0]     cfg_data
);

  swst_pkg::swst_cmd_t cmd;
  swst_pkg::swst_sts_t sts;

  assign cfg_ready = 1'b1;

  swst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swst_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_mode   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (m_tdata)
  );

endmodule

// ===== rtl/core/swst_checker.sv =====
// swst_checker: port level checks of the slot tracker, bound to the top level.
// Depends on swst_pkg and sliding_window_slot_tracker.
module swst_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [swst_pkg::OUT_DATA_W-1:0] m_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one beat in execution at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // a slot in use must be in the window
  a_use_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("in_use without in_range");

  // a free or out of window slot reports no length
  a_len_needs_use: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:2] != 16'd0) |-> m_tdata[1])
    else $error("length reported for a free slot");

  // out of window results report ring slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[23:18] == 6'd0))
    else $error("slot index set outside the window");

endmodule

bind sliding_window_slot_tracker swst_checker u_swst_checker (.*);
